### sv/rlf_pkg.sv
// Shared types and constants for the RANSAC 2D line fit block.
package rlf_pkg;

    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_ITER = 2'd0;
    localparam logic [CIDX_W-1:0] REG_TOL  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SEED = 2'd2;

    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    // One command from the front end to the fit engine.
    typedef struct packed {
        logic              wr;
        logic              run;
        logic [ADDR_W-1:0] addr;
        logic [RAW_W-1:0]  x;
        logic [RAW_W-1:0]  y;
        logic [CNT_W-1:0]  n;
        logic              dropped;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  iter;
        logic [14:0] tol;
        logic [31:0] seed;
    } cfg_t;

endpackage

### sv/rlf_front.sv
// Front end: accepts points, assigns store addresses and marks the start of a fit.
module rlf_front #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [rlf_pkg::RAW_W-1:0]     in_x,
    input  logic [rlf_pkg::RAW_W-1:0]     in_y,
    input  logic                          in_last,
    output logic                          in_ready,
    input  logic                          q_full,
    output logic                          q_push,
    output rlf_pkg::cmd_t                 q_cmd
);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic          store;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign store    = (cnt_reg < CW'(MAX_POINTS));

    always_comb begin
        q_cmd         = '0;
        q_cmd.wr      = store;
        q_cmd.run     = in_last;
        q_cmd.addr    = rlf_pkg::ADDR_W'(cnt_reg);
        q_cmd.x       = in_x;
        q_cmd.y       = in_y;
        q_cmd.n       = rlf_pkg::CNT_W'(cnt_reg + CW'(store));
        q_cmd.dropped = drop_reg || !store;
        cnt_next      = cnt_reg;
        drop_next     = drop_reg;
        if (q_push) begin
            if (in_last) begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end else begin
                cnt_next  = cnt_reg + CW'(store);
                drop_next = drop_reg || !store;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end
endmodule

### sv/rlf_queue.sv
// Four-entry command queue between the front end and the fit engine.
module rlf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rlf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output rlf_pkg::cmd_t pop_cmd,
    output logic          empty
);
    rlf_pkg::cmd_t slot_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] fill_reg;

    assign full    = (fill_reg == 3'd4);
    assign empty   = (fill_reg == 3'd0);
    assign pop_cmd = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            fill_reg <= fill_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

### sv/rlf_fit.sv
// Fit engine: point store, hypothesis sampling, inlier scan and mask output.
module rlf_fit #(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rlf_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  rlf_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_mask,
    output logic [3:0]    out_index,
    output logic [10:0]   out_total,
    output logic          out_ovf,
    output logic          out_last
);
    localparam int unsigned AW    = $clog2(MAX_POINTS);
    localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
    localparam int unsigned WORDS = (MAX_POINTS + 63) / 64;
    localparam int unsigned KW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned PW    = 2 * CB;
    localparam int unsigned UW    = 2 * CB + 3;
    localparam int unsigned UL    = (UW + 1) / 2;
    localparam int unsigned UHI   = UW - UL;
    localparam int unsigned DW    = 2 * CB + 2;
    localparam int unsigned DL    = (DW + 1) / 2;
    localparam int unsigned DHI   = DW - DL;
    localparam int unsigned RW    = 30 + DW;
    localparam int unsigned SQW   = 2 * UW;
    localparam int unsigned XW    = (SQW > RW) ? SQW : RW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DRAW = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_CO1  = 4'd5;
    localparam logic [3:0] S_CO2  = 4'd6;
    localparam logic [3:0] S_CO3  = 4'd7;
    localparam logic [3:0] S_CO4  = 4'd8;
    localparam logic [3:0] S_CO5  = 4'd9;
    localparam logic [3:0] S_SCAN = 4'd10;
    localparam logic [3:0] S_EVAL = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] st_reg;

    // Point store, x in the low half.
    logic [2*CB-1:0] mem [MAX_POINTS];
    logic [2*CB-1:0] rd_q;
    logic [AW-1:0]   rd_addr;
    logic [CB+15:0]  wx_ext, wy_ext;

    logic [CW-1:0]  n_reg;
    logic           drop_reg;
    logic [9:0]     it_reg;
    logic [29:0]    tol2_reg;
    logic [31:0]    lfsr_reg, lfsr_step;
    logic [31:0]    dq_reg;
    logic [CW-1:0]  rem_reg;
    logic [CW:0]    rem_sh;
    logic [4:0]     bit_reg;
    logic           second_reg;
    logic [AW-1:0]  i1_reg, i2_reg;
    logic [2*CB-1:0] p1_reg;

    logic signed [CB:0]   a_reg, b_reg;
    logic signed [PW-1:0] xy_reg, yx_reg;
    logic signed [PW:0]   c_reg;
    logic signed [DW-1:0] a2_reg, b2_reg;
    logic [DW-1:0]        den_reg;
    logic [30+DHI-1:0]    rph_reg;
    logic [30+DL-1:0]     rpl_reg;
    logic [XW-1:0]        rhs_reg;

    // Scan pipeline.
    logic [CW-1:0]        j_reg;
    logic                 v1, v2, v3, v4, v5;
    logic [AW-1:0]        j1, j2, j3, j4, j5;
    logic signed [PW:0]   ax_reg, by_reg;
    logic signed [UW-1:0] num;
    logic [UW-1:0]        u_reg;
    logic [2*UHI-1:0]     hh_reg;
    logic [UHI+UL-1:0]    hl_reg;
    logic [2*UL-1:0]      ll_reg;
    logic [XW-1:0]        sq_reg;
    logic [CW-1:0]        cnt_reg, best_cnt_reg;
    logic [WORDS*64-1:0]  trial_reg, best_reg;

    logic [KW-1:0]  k_reg;
    logic [CW-1:0]  nwords;
    logic           k_last;
    logic           out_load;

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ rlf_pkg::LFSR_TAPS) : (lfsr_reg >> 1);
    assign rem_sh    = {rem_reg, dq_reg[31]};
    assign wx_ext    = {{CB{1'b0}}, q_cmd.x};
    assign wy_ext    = {{CB{1'b0}}, q_cmd.y};
    assign q_pop     = (st_reg == S_IDLE) && !q_empty;
    assign num       = UW'(ax_reg) + UW'(by_reg) + UW'(c_reg);
    assign nwords    = CW'((CW + 7)'(n_reg) + (CW + 7)'(63) >> 6);
    assign k_last    = (CW'(k_reg) + CW'(1) == nwords);
    assign out_load  = (st_reg == S_OUT) && (!out_valid || out_ready);

    always_comb begin
        unique case (st_reg)
            S_RD1:   rd_addr = i1_reg;
            S_RD2:   rd_addr = i2_reg;
            default: rd_addr = j_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.wr)
            mem[q_cmd.addr[AW-1:0]] <= {wy_ext[CB-1:0], wx_ext[CB-1:0]};
        rd_q <= mem[rd_addr];
    end

    // Per-hypothesis coefficients; a multiply is always registered before use.
    always_ff @(posedge aclk) begin
        if (st_reg == S_RD2) p1_reg <= rd_q;
        if (st_reg == S_CO1) begin
            a_reg  <= (CB+1)'($signed(p1_reg[2*CB-1:CB])) - (CB+1)'($signed(rd_q[2*CB-1:CB]));
            b_reg  <= (CB+1)'($signed(rd_q[CB-1:0])) - (CB+1)'($signed(p1_reg[CB-1:0]));
            xy_reg <= $signed(p1_reg[CB-1:0]) * $signed(rd_q[2*CB-1:CB]);
            yx_reg <= $signed(rd_q[CB-1:0]) * $signed(p1_reg[2*CB-1:CB]);
        end
        if (st_reg == S_CO2) begin
            c_reg  <= (PW+1)'(xy_reg) - (PW+1)'(yx_reg);
            a2_reg <= a_reg * a_reg;
            b2_reg <= b_reg * b_reg;
        end
        if (st_reg == S_CO3) den_reg <= $unsigned(a2_reg) + $unsigned(b2_reg);
        if (st_reg == S_CO4) begin
            rph_reg <= tol2_reg * den_reg[DW-1:DL];
            rpl_reg <= tol2_reg * den_reg[DL-1:0];
        end
        if (st_reg == S_CO5) rhs_reg <= (XW'(rph_reg) << DL) + XW'(rpl_reg);
        if (q_pop && q_cmd.run) tol2_reg <= cfg.tol * cfg.tol;
    end

    always_ff @(posedge aclk) begin
        ax_reg <= a_reg * $signed(rd_q[CB-1:0]);
        by_reg <= b_reg * $signed(rd_q[2*CB-1:CB]);
        u_reg  <= num[UW-1] ? UW'(-num) : UW'(num);
        hh_reg <= u_reg[UW-1:UL] * u_reg[UW-1:UL];
        hl_reg <= u_reg[UW-1:UL] * u_reg[UL-1:0];
        ll_reg <= u_reg[UL-1:0] * u_reg[UL-1:0];
        sq_reg <= (XW'(hh_reg) << (2*UL)) + (XW'(hl_reg) << (UL+1)) + XW'(ll_reg);
        j1 <= j_reg[AW-1:0];
        j2 <= j1;
        j3 <= j2;
        j4 <= j3;
        j5 <= j4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
            out_valid    <= 1'b0;
            best_cnt_reg <= '0;
            best_reg     <= '0;
            trial_reg    <= '0;
            cnt_reg      <= '0;
            lfsr_reg     <= 32'd1;
            n_reg        <= '0;
            drop_reg     <= 1'b0;
        end else begin
            v1 <= (st_reg == S_SCAN) && (j_reg < n_reg);
            v2 <= v1;
            v3 <= v2;
            v4 <= v3;
            v5 <= v4;
            if (v5 && (sq_reg < rhs_reg)) begin
                trial_reg[j5] <= 1'b1;
                cnt_reg       <= cnt_reg + CW'(1);
            end
            if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE: begin
                    if (q_pop && q_cmd.run) begin
                        n_reg        <= q_cmd.n[CW-1:0];
                        drop_reg     <= q_cmd.dropped;
                        best_reg     <= '0;
                        best_cnt_reg <= '0;
                        lfsr_reg     <= (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
                        it_reg       <= '0;
                        second_reg   <= 1'b0;
                        k_reg        <= '0;
                        st_reg       <= (cfg.iter == 10'd0) ? S_OUT : S_DRAW;
                    end
                end
                S_DRAW: begin
                    lfsr_reg <= lfsr_step;
                    dq_reg   <= lfsr_step;
                    rem_reg  <= '0;
                    bit_reg  <= 5'd31;
                    st_reg   <= S_MOD;
                end
                S_MOD: begin
                    // Restoring remainder, one dividend bit per cycle.
                    logic [CW:0] r;
                    r = (rem_sh >= (CW+1)'(n_reg)) ? rem_sh - (CW+1)'(n_reg) : rem_sh;
                    rem_reg <= r[CW-1:0];
                    dq_reg  <= dq_reg << 1;
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        if (second_reg) begin
                            i2_reg <= r[AW-1:0];
                            st_reg <= S_RD1;
                        end else begin
                            i1_reg <= r[AW-1:0];
                            st_reg <= S_DRAW;
                        end
                        second_reg <= !second_reg;
                    end
                end
                S_RD1: st_reg <= S_RD2;
                S_RD2: st_reg <= S_CO1;
                S_CO1: st_reg <= S_CO2;
                S_CO2: st_reg <= S_CO3;
                S_CO3: st_reg <= S_CO4;
                S_CO4: st_reg <= S_CO5;
                S_CO5: begin
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    trial_reg <= '0;
                    st_reg    <= S_SCAN;
                end
                S_SCAN: begin
                    if (j_reg < n_reg) begin
                        j_reg <= j_reg + CW'(1);
                    end else if (!(v1 || v2 || v3 || v4 || v5)) begin
                        st_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (cnt_reg > best_cnt_reg) begin
                        best_cnt_reg <= cnt_reg;
                        best_reg     <= trial_reg;
                    end
                    it_reg <= it_reg + 10'd1;
                    st_reg <= (it_reg + 10'd1 == cfg.iter) ? S_OUT : S_DRAW;
                end
                S_OUT: begin
                    if (out_load) begin
                        out_valid <= 1'b1;
                        out_mask  <= best_reg[k_reg*64 +: 64];
                        out_index <= 4'(k_reg);
                        out_total <= 11'(best_cnt_reg);
                        out_ovf   <= drop_reg;
                        out_last  <= k_last;
                        k_reg     <= k_reg + KW'(1);
                        if (k_last) st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### sv/ransac_line_fit_2d_core.sv
// Top level of the RANSAC 2D line fit: configuration registers and channel wiring.
//
// Points arrive on the s_ channel, one item per cycle while s_tready is high, with
// x in s_tdata[15:0] and y in s_tdata[31:16]; s_tlast marks the last point of a
// cloud and starts the fit. Points beyond MAX_POINTS are dropped and flagged in
// the result. The fit tries iteration_count line hypotheses. Each does fixed work
// (two index draws, each a 32-step remainder, plus two store reads, five
// coefficient stages and the best-mask update) and then a pipelined inlier scan
// over the single read port of the point store. The best inlier mask then leaves
// on the m_ channel as ceil(points/64) items, m_tlast on the final one, one per
// cycle while m_tready is high. A four-entry command queue sits between the point
// intake and the fit engine, so points of the next cloud are taken while a fit
// runs until the queue fills. A stalled m_tready holds the current output item
// and pauses the engine. Configuration is written on cfg_valid (always ready);
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset (aresetn low, synchronous) restores iteration_count 35,
// tolerance 512 and seed 1, and empties the queue, the point count and the output.
module ransac_line_fit_2d_core #(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // mask_word[63:0], word_index[67:64],
                                   // inlier_total[78:68], overflow[79]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    rlf_pkg::cfg_t cfg_reg;
    rlf_pkg::cmd_t push_cmd, pop_cmd;
    logic          q_push, q_pop, q_full, q_empty;
    logic [63:0]   o_mask;
    logic [3:0]    o_index;
    logic [10:0]   o_total;
    logic          o_ovf;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {o_ovf, o_total, o_index, o_mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.iter <= 10'd35;
            cfg_reg.tol  <= 15'd512;
            cfg_reg.seed <= 32'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                rlf_pkg::REG_ITER: cfg_reg.iter <= cfg_data[9:0];
                rlf_pkg::REG_TOL:  cfg_reg.tol  <= cfg_data[14:0];
                rlf_pkg::REG_SEED: cfg_reg.seed <= cfg_data;
                default: ;
            endcase
        end
    end

    rlf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]),
        .in_last(s_tlast), .in_ready(s_tready),
        .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
    );

    rlf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_cmd(push_cmd), .full(q_full),
        .pop(q_pop), .pop_cmd(pop_cmd), .empty(q_empty)
    );

    rlf_fit #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_fit (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_empty(q_empty), .q_cmd(pop_cmd), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_mask(o_mask), .out_index(o_index), .out_total(o_total),
        .out_ovf(o_ovf), .out_last(m_tlast)
    );
endmodule
